@@ rtl/cvd_pkg.sv @@
`default_nettype none
package cvd_pkg;

	// Result kinds
	localparam logic [2:0] KIND_VARINT  = 3'd0;
	localparam logic [2:0] KIND_LENGTH  = 3'd1;
	localparam logic [2:0] KIND_BYTE    = 3'd2;
	localparam logic [2:0] KIND_TRUNC   = 3'd3;
	localparam logic [2:0] KIND_TOOLONG = 3'd4;

	// Prefix bytes that announce a 2- or 4-byte value; anything above is 8 bytes
	localparam logic [7:0] PREFIX_U16 = 8'hFD;
	localparam logic [7:0] PREFIX_U32 = 8'hFE;

	localparam logic [16:0] SIZE_CAP = 17'h10000;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_KIND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE   = 1'b1;
	localparam logic        FIELD_KIND_RST = 1'b1;
	localparam logic [16:0] MAX_SIZE_RST   = 17'd256;

	localparam int QUEUE_DEPTH_DFLT = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        last;
	} out_item_t;

	// Compact event passed from the parser to the result stage
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] data;
		logic        last;
	} op_t;

	typedef struct packed {
		logic        field_kind;
		logic [16:0] max_string_size;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

@@ rtl/cvd_queue.sv @@
`default_nettype none
module cvd_queue #(
	parameter int DEPTH = cvd_pkg::QUEUE_DEPTH_DFLT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire cvd_pkg::op_t     push_op,
	input  wire logic             pop,
	output cvd_pkg::op_t          head,
	output cvd_pkg::q_status_t    status
);
	import cvd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			ptr_inc = '0;
		end else begin
			ptr_inc = p + PTR_W'(1);
		end
	endfunction

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_op;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cvd_front.sv @@
`default_nettype none
module cvd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire cvd_pkg::in_item_t item,
	input  wire cvd_pkg::cfg_t     cfg,
	output logic                   push,
	output cvd_pkg::op_t           push_op
);
	import cvd_pkg::*;

	localparam logic [1:0] PH_PREFIX  = 2'd0;
	localparam logic [1:0] PH_VALUE   = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]  phase_q,    phase_d;
	logic [3:0]  left_q,     left_d;
	logic [2:0]  shift_q,    shift_d;
	logic [63:0] acc_q,      acc_d;
	logic [15:0] pay_left_q, pay_left_d;

	logic [63:0] acc_in;
	logic [3:0]  left_dec;
	logic [15:0] pay_dec;
	logic        fin;
	logic [63:0] fin_v;
	logic [16:0] limit;
	logic        too_long;
	logic        emit;
	op_t         op;

	assign acc_in   = acc_q | ({56'd0, item.data_byte} << {shift_q, 3'b000});
	assign left_dec = left_q - 4'd1;
	assign pay_dec  = pay_left_q - 16'd1;
	assign fin_v    = (phase_q == PH_VALUE) ? acc_in : {56'd0, item.data_byte};
	assign limit    = (cfg.max_string_size > SIZE_CAP) ? SIZE_CAP : cfg.max_string_size;
	assign too_long = (|fin_v[63:17]) || (fin_v[16:0] >= limit);

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		shift_d    = shift_q;
		acc_d      = acc_q;
		pay_left_d = pay_left_q;
		fin        = 1'b0;
		emit       = 1'b0;
		op         = '{kind: KIND_TRUNC, data: 64'd0, last: 1'b1};

		case (phase_q)
			PH_VALUE: begin
				acc_d   = acc_in;
				shift_d = shift_q + 3'd1;
				left_d  = left_dec;
				if (left_dec == 4'd0) begin
					fin = 1'b1;
				end else if (item.end_of_buffer) begin
					phase_d = PH_PREFIX;
					emit    = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				pay_left_d = pay_dec;
				if (pay_dec == 16'd0) begin
					phase_d = PH_PREFIX;
					emit    = 1'b1;
					op      = '{kind: KIND_BYTE, data: {56'd0, item.data_byte}, last: 1'b1};
				end else if (item.end_of_buffer) begin
					phase_d = PH_PREFIX;
					emit    = 1'b1;
				end else begin
					emit = 1'b1;
					op   = '{kind: KIND_BYTE, data: {56'd0, item.data_byte}, last: 1'b0};
				end
			end
			default: begin
				if (item.data_byte < PREFIX_U16) begin
					fin = 1'b1;
				end else if (item.end_of_buffer) begin
					phase_d = PH_PREFIX;
					emit    = 1'b1;
				end else begin
					phase_d = PH_VALUE;
					shift_d = 3'd0;
					acc_d   = 64'd0;
					if (item.data_byte == PREFIX_U16) begin
						left_d = 4'd2;
					end else if (item.data_byte == PREFIX_U32) begin
						left_d = 4'd4;
					end else begin
						left_d = 4'd8;
					end
				end
			end
		endcase

		// Field value complete: classify against mode, size limit, zero length and end of buffer
		if (fin) begin
			phase_d = PH_PREFIX;
			emit    = 1'b1;
			if (!cfg.field_kind) begin
				op = '{kind: KIND_VARINT, data: fin_v, last: 1'b1};
			end else if (too_long) begin
				op = '{kind: KIND_TOOLONG, data: 64'd0, last: 1'b1};
			end else if (fin_v == 64'd0) begin
				op = '{kind: KIND_LENGTH, data: 64'd0, last: 1'b1};
			end else if (item.end_of_buffer) begin
				op = '{kind: KIND_TRUNC, data: 64'd0, last: 1'b1};
			end else begin
				phase_d    = PH_PAYLOAD;
				pay_left_d = fin_v[15:0];
				op         = '{kind: KIND_LENGTH, data: fin_v, last: 1'b0};
			end
		end

		// Leaving a field clears the field state
		if (phase_d == PH_PREFIX) begin
			left_d     = 4'd0;
			shift_d    = 3'd0;
			acc_d      = 64'd0;
			pay_left_d = 16'd0;
		end
	end

	assign push    = accept && emit;
	assign push_op = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PREFIX;
			left_q     <= 4'd0;
			shift_q    <= 3'd0;
			acc_q      <= 64'd0;
			pay_left_q <= 16'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			left_q     <= left_d;
			shift_q    <= shift_d;
			acc_q      <= acc_d;
			pay_left_q <= pay_left_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cvd_back.sv @@
`default_nettype none
module cvd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cvd_pkg::op_t       head,
	input  wire logic               head_valid,
	output logic                    pop,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output cvd_pkg::out_item_t      res_item
);
	import cvd_pkg::*;

	logic      valid_q;
	out_item_t item_q;
	out_item_t item_d;
	logic      is_value;

	assign is_value = (head.kind == KIND_VARINT) || (head.kind == KIND_LENGTH);

	// Expand the compact event into the result layout
	always_comb begin
		item_d.kind         = head.kind;
		item_d.value        = is_value ? head.data : 64'd0;
		item_d.payload_byte = (head.kind == KIND_BYTE) ? head.data[7:0] : 8'd0;
		item_d.last         = head.last;
	end

	assign pop       = head_valid && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/compactsize_varstr_decoder.sv @@
// Latency: the accepted byte causing a result writes an event into the event queue; the event
// then moves into the output register once it is free, raising res_valid until res_ready takes it.
// Throughput: one byte per cycle while the event queue is not full; the front stage parses each byte as it is accepted.
// A wide prefix and every value byte but the last produce nothing unless the byte ends the buffer (truncation).
// Reset: arst_n clears the parser state, the event queue and the output valid flag;
// field_kind resets to string mode and max_string_size to 256. No clearing pass is needed.
`default_nettype none
module compactsize_varstr_decoder #(
	parameter int QUEUE_DEPTH = cvd_pkg::QUEUE_DEPTH_DFLT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              byte_valid,
	output logic                                   byte_ready,
	input  wire cvd_pkg::in_item_t                 byte_item,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output cvd_pkg::out_item_t                     res_item,
	input  wire logic                              cfg_we,
	input  wire logic [cvd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [16:0]                       cfg_data
);
	import cvd_pkg::*;

	cfg_t      cfg_q;
	logic      accept;
	logic      push;
	op_t       push_op;
	op_t       head;
	logic      pop;
	q_status_t q_status;

	// Configuration registers: the user must write them only while the decoder is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_kind      <= FIELD_KIND_RST;
			cfg_q.max_string_size <= MAX_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIELD_KIND: cfg_q.field_kind      <= cfg_data[0];
				CFG_MAX_SIZE:   cfg_q.max_string_size <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a request whenever the event queue has room; every byte pushes
	// at most one event, so room for one is enough.
	assign byte_ready = !q_status.full;
	assign accept     = byte_valid && byte_ready;

	// Front: parse the byte stream, track phase, accumulate values and
	// classify complete fields into events
	cvd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (byte_item),
		.cfg     (cfg_q),
		.push    (push),
		.push_op (push_op)
	);

	// Queue: decouple the parser from output back-pressure
	cvd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	// Back: expand events into results and hold them until taken
	cvd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_status.empty),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

`ifndef SYNTHESIS
	// Error results always close the field
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.kind == KIND_TRUNC || res_item.kind == KIND_TOOLONG)
		|-> res_item.last)
		else $error("error result without last");

	// Only value-carrying kinds report a nonzero value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind != KIND_VARINT && res_item.kind != KIND_LENGTH
		|-> res_item.value == 64'd0)
		else $error("nonzero value on a result that carries none");

	// A queued event reaches the output as soon as the output is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!q_status.empty && (!res_valid || res_ready) |=> res_valid)
		else $error("queued event not moved to output");

	// A full queue never takes a push
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into full queue");
`endif

endmodule
`default_nettype wire
